FILE: rtl/core/irue_pkg.sv
// ----------------------------------------------------------------------------
// irue_pkg
// Shared types, constants and helper functions for the ident reply
// user extractor.
// ----------------------------------------------------------------------------
package irue_pkg;

    localparam int MAX_NAME_CHARS = 10;
    localparam int MAX_MSG_BYTES  = 512;

    localparam int CHARS_W = 4;
    localparam int BCNT_W  = 10;

    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    localparam logic ITEM_NAME    = 1'b0;
    localparam logic ITEM_VERDICT = 1'b1;
    localparam logic VERDICT_OK   = 1'b0;
    localparam logic VERDICT_BAD  = 1'b1;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_TILDE = 8'h7E;

    localparam logic [2:0] KW_LAST = 3'd5;

    typedef enum logic [1:0] {
        FP_PORTS,
        FP_KEYWORD,
        FP_OS,
        FP_NAME
    } field_phase_t;

    typedef enum logic [1:0] {
        PP_SKIP,
        PP_DIGITS,
        PP_DONE
    } port_phase_t;

    typedef struct packed {
        port_phase_t phase;
        logic        nonzero;
    } port_state_t;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] name_char;
        logic       verdict;
        logic       final_item;
    } out_item_t;

    typedef struct packed {
        logic      char_valid;
        out_item_t char_item;
        logic      verdict_valid;
        out_item_t verdict_item;
    } push_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // "USERID"; codes past the end wrap like the position modulo six
    function automatic logic [7:0] kw_char(input logic [2:0] pos);
        logic [7:0] r;
        case (pos)
            3'd0:    r = 8'h55;
            3'd1:    r = 8'h53;
            3'd2:    r = 8'h45;
            3'd3:    r = 8'h52;
            3'd4:    r = 8'h49;
            3'd5:    r = 8'h44;
            3'd6:    r = 8'h55;
            default: r = 8'h53;
        endcase
        return r;
    endfunction

    // atoi-style scan: skip whitespace, optional sign, digit run
    function automatic port_state_t port_feed(input port_state_t s, input logic [7:0] c);
        port_state_t r;
        r = s;
        case (s.phase)
            PP_SKIP:
            begin
                if (!is_ws(c))
                begin
                    if ((c == CH_PLUS) || (c == CH_MINUS))
                    begin
                        r.phase = PP_DIGITS;
                    end
                    else if (is_digit(c))
                    begin
                        if (c != CH_ZERO)
                        begin
                            r.nonzero = 1'b1;
                        end
                        r.phase = PP_DIGITS;
                    end
                    else
                    begin
                        r.phase = PP_DONE;
                    end
                end
            end
            PP_DIGITS:
            begin
                if (is_digit(c))
                begin
                    if (c != CH_ZERO)
                    begin
                        r.nonzero = 1'b1;
                    end
                end
                else
                begin
                    r.phase = PP_DONE;
                end
            end
            default:
            begin
                r = s;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: rtl/core/irue_parser.sv
// ----------------------------------------------------------------------------
// irue_parser
// Reply field tracker: consumes one registered byte per advance and
// produces up to two result words (name character, then verdict).
// ----------------------------------------------------------------------------
module irue_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic [7:0]        rx_byte_q,
    input  logic              last_q,
    output irue_pkg::push_t   push
);
    import irue_pkg::*;

    field_phase_t         field_phase_reg,   field_phase_upd;
    logic                 comma_seen_reg,    comma_seen_upd;
    port_state_t          port1_reg,         port1_upd;
    port_state_t          port2_reg,         port2_upd;
    logic [2:0]           kw_pos_reg,        kw_pos_upd;
    logic                 kw_found_reg,      kw_found_upd;
    logic                 lead_skip_reg,     lead_skip_upd;
    logic [CHARS_W-1:0]   chars_left_reg,    chars_left_upd;
    logic                 name_stopped_reg,  name_stopped_upd;
    logic                 text_ended_reg,    text_ended_upd;
    logic [BCNT_W-1:0]    byte_count_reg,    byte_count_upd;

    logic                 byte_live;
    logic                 reply_ok_now;
    logic                 reply_ok_upd;
    logic                 name_take;
    logic                 char_emit;

    assign byte_live    = (byte_count_reg < BCNT_W'(MAX_MSG_BYTES)) && !text_ended_reg;
    assign reply_ok_now = (field_phase_reg == FP_NAME) && comma_seen_reg &&
                          port1_reg.nonzero && port2_reg.nonzero && kw_found_reg;

    // next state for one byte, before the end-of-reply reset
    always_comb
    begin
        field_phase_upd  = field_phase_reg;
        comma_seen_upd   = comma_seen_reg;
        port1_upd        = port1_reg;
        port2_upd        = port2_reg;
        kw_pos_upd       = kw_pos_reg;
        kw_found_upd     = kw_found_reg;
        lead_skip_upd    = lead_skip_reg;
        chars_left_upd   = chars_left_reg;
        name_stopped_upd = name_stopped_reg;
        text_ended_upd   = text_ended_reg;
        byte_count_upd   = byte_count_reg;
        name_take        = 1'b0;
        char_emit        = 1'b0;

        if (byte_live)
        begin
            byte_count_upd = byte_count_reg + BCNT_W'(1);
            if (rx_byte_q == CH_NUL)
            begin
                text_ended_upd = 1'b1;
            end
            else
            begin
                case (field_phase_reg)
                    FP_PORTS:
                    begin
                        if (rx_byte_q == CH_COLON)
                        begin
                            field_phase_upd = FP_KEYWORD;
                        end
                        else if (!comma_seen_reg)
                        begin
                            if (rx_byte_q == CH_COMMA)
                            begin
                                comma_seen_upd = 1'b1;
                            end
                            else
                            begin
                                port1_upd = port_feed(port1_reg, rx_byte_q);
                            end
                        end
                        else
                        begin
                            port2_upd = port_feed(port2_reg, rx_byte_q);
                        end
                    end
                    FP_KEYWORD:
                    begin
                        if (rx_byte_q == CH_COLON)
                        begin
                            field_phase_upd = FP_OS;
                        end
                        else if (rx_byte_q == kw_char(kw_pos_reg))
                        begin
                            if (kw_pos_reg == KW_LAST)
                            begin
                                kw_found_upd = 1'b1;
                                kw_pos_upd   = 3'd0;
                            end
                            else
                            begin
                                kw_pos_upd = kw_pos_reg + 3'd1;
                            end
                        end
                        else
                        begin
                            kw_pos_upd = (rx_byte_q == kw_char(3'd0)) ? 3'd1 : 3'd0;
                        end
                    end
                    FP_OS:
                    begin
                        if (rx_byte_q == CH_COLON)
                        begin
                            field_phase_upd = FP_NAME;
                        end
                    end
                    default:
                    begin
                        if (reply_ok_now && !name_stopped_reg &&
                            (chars_left_reg != '0))
                        begin
                            name_take = 1'b1;
                            if (lead_skip_reg)
                            begin
                                if ((rx_byte_q == CH_TILDE) || (rx_byte_q == CH_CARET))
                                begin
                                    name_take = 1'b0;
                                end
                                else
                                begin
                                    lead_skip_upd = 1'b0;
                                end
                            end
                            if (name_take)
                            begin
                                if (rx_byte_q == CH_AT)
                                begin
                                    name_stopped_upd = 1'b1;
                                end
                                else if (!is_ws(rx_byte_q) && (rx_byte_q != CH_COLON) &&
                                         (rx_byte_q != CH_LBRK))
                                begin
                                    char_emit      = 1'b1;
                                    chars_left_upd = chars_left_reg - CHARS_W'(1);
                                end
                            end
                        end
                    end
                endcase
            end
        end
    end

    assign reply_ok_upd = (field_phase_upd == FP_NAME) && comma_seen_upd &&
                          port1_upd.nonzero && port2_upd.nonzero && kw_found_upd;

    // result words
    always_comb
    begin
        push.char_valid              = adv && char_emit;
        push.char_item.item_kind     = ITEM_NAME;
        push.char_item.name_char     = rx_byte_q;
        push.char_item.verdict       = VERDICT_OK;
        push.char_item.final_item    = 1'b0;
        push.verdict_valid           = adv && last_q;
        push.verdict_item.item_kind  = ITEM_VERDICT;
        push.verdict_item.name_char  = 8'h00;
        push.verdict_item.verdict    = reply_ok_upd ? VERDICT_OK : VERDICT_BAD;
        push.verdict_item.final_item = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            field_phase_reg  <= FP_PORTS;
            comma_seen_reg   <= 1'b0;
            port1_reg        <= '{phase: PP_SKIP, nonzero: 1'b0};
            port2_reg        <= '{phase: PP_SKIP, nonzero: 1'b0};
            kw_pos_reg       <= 3'd0;
            kw_found_reg     <= 1'b0;
            lead_skip_reg    <= 1'b1;
            chars_left_reg   <= CHARS_W'(MAX_NAME_CHARS);
            name_stopped_reg <= 1'b0;
            text_ended_reg   <= 1'b0;
            byte_count_reg   <= '0;
        end
        else if (adv)
        begin
            if (last_q)
            begin
                // reply closed: back to the start state
                field_phase_reg  <= FP_PORTS;
                comma_seen_reg   <= 1'b0;
                port1_reg        <= '{phase: PP_SKIP, nonzero: 1'b0};
                port2_reg        <= '{phase: PP_SKIP, nonzero: 1'b0};
                kw_pos_reg       <= 3'd0;
                kw_found_reg     <= 1'b0;
                lead_skip_reg    <= 1'b1;
                chars_left_reg   <= CHARS_W'(MAX_NAME_CHARS);
                name_stopped_reg <= 1'b0;
                text_ended_reg   <= 1'b0;
                byte_count_reg   <= '0;
            end
            else
            begin
                field_phase_reg  <= field_phase_upd;
                comma_seen_reg   <= comma_seen_upd;
                port1_reg        <= port1_upd;
                port2_reg        <= port2_upd;
                kw_pos_reg       <= kw_pos_upd;
                kw_found_reg     <= kw_found_upd;
                lead_skip_reg    <= lead_skip_upd;
                chars_left_reg   <= chars_left_upd;
                name_stopped_reg <= name_stopped_upd;
                text_ended_reg   <= text_ended_upd;
                byte_count_reg   <= byte_count_upd;
            end
        end
    end

`ifndef SYNTH
    a_verdict_resets: assert property (@(posedge clk) disable iff (!rst_n)
        push.verdict_valid |=> (field_phase_reg == FP_PORTS) && (byte_count_reg == '0) &&
                               (chars_left_reg == CHARS_W'(MAX_NAME_CHARS)))
        else $error("parser state not cleared after verdict");

    a_char_needs_valid_reply: assert property (@(posedge clk) disable iff (!rst_n)
        push.char_valid |-> (field_phase_reg == FP_NAME) && comma_seen_reg &&
                            kw_found_reg && port1_reg.nonzero && port2_reg.nonzero)
        else $error("name character emitted for a reply that is not valid");

    a_chars_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        push.char_valid |=> (chars_left_reg < CHARS_W'(MAX_NAME_CHARS)) || push.verdict_valid
                            || $past(last_q))
        else $error("name character not counted");
`endif

endmodule

FILE: rtl/core/irue_out_fifo.sv
// ----------------------------------------------------------------------------
// irue_out_fifo
// Small result queue: takes up to two words per cycle, hands out one unless out_stall is high.
// ----------------------------------------------------------------------------
module irue_out_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  irue_pkg::push_t     push,
    input  logic                out_stall,
    output logic                out_valid,
    output irue_pkg::out_item_t head,
    output logic                room
);
    import irue_pkg::*;

    out_item_t          entry_reg [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FCNT_W-1:0]  count_reg,  count_next;
    logic [1:0]         push_cnt;
    logic               pop;
    logic [PTR_W-1:0]   verdict_ptr;

    assign out_valid   = (count_reg != '0);
    assign head        = entry_reg[rd_ptr_reg];
    assign pop         = out_valid && !out_stall;
    assign room        = (count_reg <= FCNT_W'(FIFO_DEPTH - 2));
    assign push_cnt    = {1'b0, push.char_valid} + {1'b0, push.verdict_valid};
    assign verdict_ptr = push.char_valid ? (wr_ptr_reg + PTR_W'(1)) : wr_ptr_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
        count_next  = count_reg + FCNT_W'(push_cnt) - FCNT_W'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push.char_valid)
        begin
            entry_reg[wr_ptr_reg] <= push.char_item;
        end
        if (push.verdict_valid)
        begin
            entry_reg[verdict_ptr] <= push.verdict_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt != 2'd0) |-> (count_reg <= FCNT_W'(FIFO_DEPTH - 2)))
        else $error("result queue written without room");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FCNT_W'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (push_cnt == 2'd2) |-> (push.char_item.item_kind == ITEM_NAME) &&
                               (push.verdict_item.item_kind == ITEM_VERDICT))
        else $error("name and verdict words out of order");
`endif

endmodule

FILE: rtl/core/ident_reply_user_extractor_unit.sv
// ----------------------------------------------------------------------------
// ident_reply_user_extractor_unit
// Byte-serial ident reply parser that emits the user name and a verdict.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_stall): one reply byte per word, end_of_reply
// set on the last byte of a reply. Output channel (out_valid/out_stall):
// result words, either a kept user name character (item_kind 0) or the
// closing verdict (item_kind 1, final_item 1, verdict 0 = valid reply).
// A byte is taken into an input register, parsed from there once the
// queue has room, and its words pushed into a four-word result queue.
// Throughput is one byte per cycle while the queue has room; a final
// byte that also yields a name character gives two words, and the
// single output port then sets the pace. The input stalls while a byte
// waits in the input register and the queue holds more than two words.
// Reset clears the parser to the start of a reply and empties the queue.
// While the receiver stalls, the head word stays on the outputs and the
// queue fills until the input stalls in turn; no word is dropped.
// ----------------------------------------------------------------------------
module ident_reply_user_extractor_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] rx_byte,
    input  logic       end_of_reply,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       item_kind,
    output logic [7:0] name_char,
    output logic       verdict,
    output logic       final_item
);
    import irue_pkg::*;

    logic       s1_valid_reg, s1_valid_next;
    logic [7:0] s1_byte_reg;
    logic       s1_last_reg;
    logic       in_accept;
    logic       adv;
    logic       room;
    push_t      push;
    out_item_t  head;

    assign adv       = s1_valid_reg && room;
    assign in_stall  = s1_valid_reg && !room;
    assign in_accept = in_valid && !in_stall;

    always_comb
    begin
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (adv)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_byte_reg <= rx_byte;
            s1_last_reg <= end_of_reply;
        end
    end

    irue_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .rx_byte_q (s1_byte_reg),
        .last_q    (s1_last_reg),
        .push      (push)
    );

    irue_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .head      (head),
        .room      (room)
    );

    assign item_kind  = head.item_kind;
    assign name_char  = head.name_char;
    assign verdict    = head.verdict;
    assign final_item = head.final_item;

endmodule
